// ===== hw/rtl/tvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared types and register codes for the trapezoidal velocity profile block.
// ----------------------------------------------------------------------------
package tvp_pkg;

  typedef enum logic [0:0] {
    REG_SPEED_LIMIT = 1'b0,
    REG_ACCEL_LIMIT = 1'b1
  } reg_idx_e;

endpackage

// ===== hw/rtl/tvp_if.sv =====
// ----------------------------------------------------------------------------
// tvp_seg_if / tvp_res_if
// Valid/ready channels for segments and profile results.
// ----------------------------------------------------------------------------
interface tvp_seg_if #(parameter int DW = 32);
  logic          valid;
  logic          ready;
  logic [DW-1:0] segment_length;
  logic [DW-1:0] start_speed;
  logic [DW-1:0] end_speed;
  modport source (output valid, segment_length, start_speed, end_speed, input ready);
  modport sink   (input valid, segment_length, start_speed, end_speed, output ready);
endinterface

interface tvp_res_if #(parameter int DW = 32);
  logic          valid;
  logic          ready;
  logic [DW-2:0] peak_speed;
  logic [DW-1:0] ramp_up_time;
  logic [DW-1:0] cruise_duration;
  logic [DW-1:0] ramp_down_time;
  logic [DW-1:0] segment_time;
  logic          degenerate;
  modport source (output valid, peak_speed, ramp_up_time, cruise_duration,
                  ramp_down_time, segment_time, degenerate, input ready);
  modport sink   (input valid, peak_speed, ramp_up_time, cruise_duration,
                  ramp_down_time, segment_time, degenerate, output ready);
endinterface

// ===== hw/rtl/trapezoidal_velocity_profile_top.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_velocity_profile_top
// Trapezoidal profile of one segment: peak speed, phase times, total time.
// ----------------------------------------------------------------------------
// Depth: DATA_WIDTH + 2*(2*DATA_WIDTH+2) + 6 register stages (170 at 32 bits)
//   from the input transfer to the result (one square-root bit and one quotient
//   bit per stage, so the long chains set the depth).
// Throughput: one segment per cycle; a stalled output freezes all stages.
// Reset: rst_ni asynchronous, clears valid bits and both limit registers.
// ----------------------------------------------------------------------------
module trapezoidal_velocity_profile_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tvp_seg_if.sink     seg,
  tvp_res_if.source   res
);
  localparam int DW = DATA_WIDTH;
  localparam int RW = DW;          // root width
  localparam int SW = 2*DW + 2;    // radicand width
  localparam int NW = 2*DW + 2;    // dividend / divider width
  localparam int NS = RW;          // sqrt stages
  localparam int QB = NW;          // quotient bits per division
  localparam logic [DW-1:0] MAXW = '1;
  localparam logic [DW-1:0] PCAP = DW'({(DW-1){1'b1}});

  // ---------------- configuration ----------------
  logic [DW-1:0] vmax_q, amax_q;
  logic          wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_q <= '0;
      amax_q <= '0;
    end else if (wr && paddr[2] == 1'b0) begin
      unique case (tvp_pkg::reg_idx_e'(paddr[2]))
        tvp_pkg::REG_SPEED_LIMIT: vmax_q <= DW'(pwdata);
        tvp_pkg::REG_ACCEL_LIMIT: amax_q <= DW'(pwdata);
        default: ;
      endcase
    end else if (wr && paddr[2] == 1'b1) begin
      amax_q <= DW'(pwdata);
    end
  end
  always_comb begin
    prdata = '0;
    unique case (tvp_pkg::reg_idx_e'(paddr[2]))
      tvp_pkg::REG_SPEED_LIMIT: prdata = 32'(vmax_q);
      tvp_pkg::REG_ACCEL_LIMIT: prdata = 32'(amax_q);
      default: prdata = '0;
    endcase
  end

  // global advance: the whole pipe moves unless the output holds a result that is not taken
  logic adv;
  assign adv = !res.valid || res.ready;
  assign seg.ready = adv;

  // ---------------- stage A: clamp, squares, radicand ----------------
  typedef struct packed {
    logic          v;
    logic          dg;
    logic [DW-1:0] len, ve, vx, a, cap;
    logic [SW-1:0] ve2, vx2, rad;
  } sa_t;
  sa_t a1_q, a2_q;
  logic [DW-1:0] len_c, ve_c, vx_c;
  assign len_c = seg.segment_length[DW-1] ? '0 : seg.segment_length;
  assign ve_c  = seg.start_speed[DW-1]    ? '0 : seg.start_speed;
  assign vx_c  = seg.end_speed[DW-1]      ? '0 : seg.end_speed;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q.v <= 1'b0;
      a2_q.v <= 1'b0;
    end else if (adv) begin
      a1_q.v   <= seg.valid;
      a1_q.dg  <= len_c == '0 || amax_q == '0 || vmax_q == '0;
      a1_q.len <= len_c; a1_q.ve <= ve_c; a1_q.vx <= vx_c; a1_q.a <= amax_q;
      a1_q.cap <= (vmax_q < PCAP) ? vmax_q : PCAP;
      a1_q.ve2 <= SW'(ve_c) * SW'(ve_c);
      a1_q.vx2 <= SW'(vx_c) * SW'(vx_c);
      a1_q.rad <= SW'(amax_q) * SW'(len_c);   // a*L; times two halved away
      a2_q     <= a1_q;
      a2_q.rad <= a1_q.rad + ((a1_q.ve2 + a1_q.vx2) >> 1);
    end
  end

  // ---------------- sqrt pipeline: one bit per stage ----------------
  typedef struct packed {
    logic          v, dg;
    logic [DW-1:0] len, ve, vx, a, cap;
    logic [SW-1:0] ve2, vx2, rad;
    logic [RW-1:0] root;
  } sq_t;
  sq_t sq_q [NS+1];
  always_comb begin
    sq_q[0] = '{v: a2_q.v, dg: a2_q.dg, len: a2_q.len, ve: a2_q.ve, vx: a2_q.vx,
               a: a2_q.a, cap: a2_q.cap, ve2: a2_q.ve2, vx2: a2_q.vx2,
               rad: a2_q.rad, root: '0};
  end
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [RW-1:0] nroot;
    sq_t           st_q;
    tvp_sqrt_stage #(.RW(RW), .SW(SW), .BIT(NS-1-k)) u_st (
      .rad_i(sq_q[k].rad), .root_i(sq_q[k].root), .root_o(nroot));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) st_q.v <= 1'b0;
      else if (adv) begin
        st_q      <= sq_q[k];
        st_q.root <= nroot;
      end
    end
    assign sq_q[k+1] = st_q;
  end

  // ---------------- stage B: cap, p^2 ----------------
  typedef struct packed {
    logic          v, dg;
    logic [DW-1:0] len, ve, vx, a, p;
    logic [SW-1:0] ve2, vx2, p2;
  } sb_t;
  sb_t b1_q, b2_q;
  logic [DW-1:0] p_c;
  assign p_c = (sq_q[NS].root > sq_q[NS].cap) ? sq_q[NS].cap : sq_q[NS].root;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q.v <= 1'b0;
      b2_q.v <= 1'b0;
    end else if (adv) begin
      b1_q <= '{v: sq_q[NS].v, dg: sq_q[NS].dg, len: sq_q[NS].len, ve: sq_q[NS].ve,
               vx: sq_q[NS].vx, a: sq_q[NS].a, p: p_c, ve2: sq_q[NS].ve2,
               vx2: sq_q[NS].vx2, p2: '0};
      b2_q    <= b1_q;
      b2_q.p2 <= SW'(b1_q.p) * SW'(b1_q.p);
    end
  end

  // ---------------- division 1: da, dd over 2a ----------------
  typedef struct packed {
    logic          v, dg;
    logic [DW-1:0] len, ve, vx, a, p;
    logic [NW-1:0] n0, n1;
    logic [NW:0]   r0, r1;
    logic [NW-1:0] q0, q1;
  } d1_t;
  d1_t d1 [QB+1];
  always_comb begin
    d1[0] = '0;
    d1[0].v = b2_q.v; d1[0].dg = b2_q.dg; d1[0].len = b2_q.len;
    d1[0].ve = b2_q.ve; d1[0].vx = b2_q.vx; d1[0].a = b2_q.a; d1[0].p = b2_q.p;
    d1[0].n0 = (b2_q.p2 > b2_q.ve2) ? NW'(b2_q.p2 - b2_q.ve2) : '0;
    d1[0].n1 = (b2_q.p2 > b2_q.vx2) ? NW'(b2_q.p2 - b2_q.vx2) : '0;
  end
  for (genvar k = 0; k < QB; k++) begin : g_d1
    logic [NW:0]   r0, r1;
    logic          b0, b1;
    logic [NW-1:0] den;
    d1_t           st_q;
    assign den = NW'({d1[k].a, 1'b0});
    tvp_div_stage #(.DW(NW)) u0 (.rem_i(d1[k].r0), .nbit_i(d1[k].n0[QB-1-k]),
      .den_i(den), .rem_o(r0), .qbit_o(b0));
    tvp_div_stage #(.DW(NW)) u1 (.rem_i(d1[k].r1), .nbit_i(d1[k].n1[QB-1-k]),
      .den_i(den), .rem_o(r1), .qbit_o(b1));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) st_q.v <= 1'b0;
      else if (adv) begin
        st_q    <= d1[k];
        st_q.r0 <= r0; st_q.r1 <= r1;
        st_q.q0 <= {d1[k].q0[NW-2:0], b0};
        st_q.q1 <= {d1[k].q1[NW-2:0], b1};
      end
    end
    assign d1[k+1] = st_q;
  end

  // ---------------- stage C: saturate, cruise distance ----------------
  typedef struct packed {
    logic          v, dg;
    logic [DW-1:0] ve, vx, a, p, cd;
  } sc_t;
  sc_t c_q;
  logic [DW-1:0] da_s, dd_s;
  logic [DW+1:0] dsum;
  assign da_s = (d1[QB].q0 > NW'(MAXW)) ? MAXW : d1[QB].q0[DW-1:0];
  assign dd_s = (d1[QB].q1 > NW'(MAXW)) ? MAXW : d1[QB].q1[DW-1:0];
  assign dsum = (DW+2)'(da_s) + (DW+2)'(dd_s);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_q.v <= 1'b0;
    else if (adv) begin
      c_q.v <= d1[QB].v; c_q.dg <= d1[QB].dg;
      c_q.ve <= d1[QB].ve; c_q.vx <= d1[QB].vx; c_q.a <= d1[QB].a; c_q.p <= d1[QB].p;
      c_q.cd <= (dsum < (DW+2)'(d1[QB].len)) ? DW'((DW+2)'(d1[QB].len) - dsum) : '0;
    end
  end

  // ---------------- division 2: ta, td over a; tc over p ----------------
  typedef struct packed {
    logic          v, dg;
    logic [DW-1:0] ve, vx, a, p;
    logic [NW-1:0] n0, n1, n2;
    logic [NW:0]   r0, r1, r2;
    logic [NW-1:0] q0, q1, q2;
  } d2_t;
  d2_t d2 [QB+1];
  always_comb begin
    d2[0] = '0;
    d2[0].v = c_q.v; d2[0].dg = c_q.dg; d2[0].ve = c_q.ve; d2[0].vx = c_q.vx;
    d2[0].a = c_q.a; d2[0].p = c_q.p;
    d2[0].n0 = (c_q.p > c_q.ve) ? (NW'(c_q.p - c_q.ve) << FRAC_BITS) : '0;
    d2[0].n1 = (c_q.p > c_q.vx) ? (NW'(c_q.p - c_q.vx) << FRAC_BITS) : '0;
    d2[0].n2 = NW'(c_q.cd) << FRAC_BITS;
  end
  for (genvar k = 0; k < QB; k++) begin : g_d2
    logic [NW:0]   r0, r1, r2;
    logic          b0, b1, b2;
    logic [NW-1:0] dena, denp;
    d2_t           st_q;
    assign dena = NW'(d2[k].a);
    assign denp = (d2[k].p == '0) ? NW'(1) : NW'(d2[k].p);
    tvp_div_stage #(.DW(NW)) u0 (.rem_i(d2[k].r0), .nbit_i(d2[k].n0[QB-1-k]),
      .den_i(dena), .rem_o(r0), .qbit_o(b0));
    tvp_div_stage #(.DW(NW)) u1 (.rem_i(d2[k].r1), .nbit_i(d2[k].n1[QB-1-k]),
      .den_i(dena), .rem_o(r1), .qbit_o(b1));
    tvp_div_stage #(.DW(NW)) u2 (.rem_i(d2[k].r2), .nbit_i(d2[k].n2[QB-1-k]),
      .den_i(denp), .rem_o(r2), .qbit_o(b2));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) st_q.v <= 1'b0;
      else if (adv) begin
        st_q    <= d2[k];
        st_q.r0 <= r0; st_q.r1 <= r1; st_q.r2 <= r2;
        st_q.q0 <= {d2[k].q0[NW-2:0], b0};
        st_q.q1 <= {d2[k].q1[NW-2:0], b1};
        st_q.q2 <= {d2[k].q2[NW-2:0], (d2[k].p == '0) ? 1'b0 : b2};
      end
    end
    assign d2[k+1] = st_q;
  end

  // ---------------- output register ----------------
  logic [DW-1:0] ta_s, tc_s, td_s, pk;
  logic [DW+1:0] tsum;
  assign ta_s = (d2[QB].q0 > NW'(MAXW)) ? MAXW : d2[QB].q0[DW-1:0];
  assign td_s = (d2[QB].q1 > NW'(MAXW)) ? MAXW : d2[QB].q1[DW-1:0];
  assign tc_s = (d2[QB].q2 > NW'(MAXW)) ? MAXW : d2[QB].q2[DW-1:0];
  assign tsum = (DW+2)'(ta_s) + (DW+2)'(tc_s) + (DW+2)'(td_s);
  assign pk   = (d2[QB].ve > d2[QB].vx) ? d2[QB].ve : d2[QB].vx;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res.valid <= 1'b0;
    else if (adv) begin
      res.valid      <= d2[QB].v;
      res.degenerate <= d2[QB].dg;
      if (d2[QB].dg) begin
        res.peak_speed      <= pk[DW-2:0];
        res.ramp_up_time    <= '0;
        res.cruise_duration <= '0;
        res.ramp_down_time  <= '0;
        res.segment_time    <= '0;
      end else begin
        res.peak_speed      <= d2[QB].p[DW-2:0];
        res.ramp_up_time    <= ta_s;
        res.cruise_duration <= tc_s;
        res.ramp_down_time  <= td_s;
        res.segment_time    <= (tsum > (DW+2)'(MAXW)) ? MAXW : tsum[DW-1:0];
      end
    end
  end

  // ---------------- assertions ----------------
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res.ready |=> res.valid && $stable(res.segment_time))
    else $error("result changed under stall");
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.degenerate |-> res.segment_time == '0)
    else $error("degenerate result has nonzero time");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res.valid |-> seg.ready)
    else $error("input stalled with empty output");
endmodule

// ===== hw/rtl/tvp_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// tvp_sqrt_stage
// One restoring square-root step: tries one result bit against the radicand.
// ----------------------------------------------------------------------------
module tvp_sqrt_stage #(
  parameter int RW  = 64,
  parameter int SW  = 128,
  parameter int BIT = 0
) (
  input  logic [SW-1:0] rad_i,
  input  logic [RW-1:0] root_i,
  output logic [RW-1:0] root_o
);
  logic [RW-1:0] trial;
  logic [SW-1:0] sq;
  assign trial  = root_i | (RW'(1) << BIT);
  assign sq     = SW'(trial) * SW'(trial);
  assign root_o = (sq <= rad_i) ? trial : root_i;
endmodule

// ===== hw/rtl/tvp_div_stage.sv =====
// ----------------------------------------------------------------------------
// tvp_div_stage
// One restoring division step on a partial remainder.
// ----------------------------------------------------------------------------
module tvp_div_stage #(
  parameter int DW = 64
) (
  input  logic [DW:0]   rem_i,
  input  logic          nbit_i,
  input  logic [DW-1:0] den_i,
  output logic [DW:0]   rem_o,
  output logic          qbit_o
);
  logic [DW+1:0] sh;
  assign sh     = {rem_i, nbit_i};
  assign qbit_o = sh >= (DW+2)'(den_i);
  assign rem_o  = qbit_o ? (DW+1)'(sh - (DW+2)'(den_i)) : sh[DW:0];
endmodule
